### design/smd_pkg.sv
// Shared types and constants for the signed multiply-divide block.
package smd_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul_step;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic slot_free;
	} stat_t;

endpackage

### design/smd_if.sv
// Request channel interfaces: operand request and result request.
interface smd_in_if #(
	parameter int W = smd_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] multiplicand;
	logic signed [W-1:0] multiplier;
	logic signed [W-1:0] divisor;

	modport source (output valid, multiplicand, multiplier, divisor, input ready);
	modport sink   (input valid, multiplicand, multiplier, divisor, output ready);
endinterface

interface smd_out_if #(
	parameter int W = smd_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] quotient;
	logic signed [W-1:0] remainder;

	modport source (output valid, quotient, remainder, input ready);
	modport sink   (input valid, quotient, remainder, output ready);
endinterface

### design/smd_ctrl.sv
// Controller: sequences load, divide steps, multiply steps and result write.
module smd_ctrl #(
	parameter int DATA_WIDTH = smd_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  smd_pkg::stat_t stat,
	output smd_pkg::cmd_t  cmd
);
	import smd_pkg::*;

	localparam int CW = $clog2(DATA_WIDTH);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          last;

	assign last = (cnt_q == CW'(DATA_WIDTH - 1));

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last) begin
					cnt_d   = '0;
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (last) begin
					cnt_d   = '0;
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				// wait for the result register to free up
				if (stat.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/smd_dp.sv
// Datapath: magnitudes, restoring divide, shift-and-add scaling, signs, result register.
module smd_dp #(
	parameter int DATA_WIDTH = smd_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smd_pkg::cmd_t         cmd,
	output smd_pkg::stat_t        stat,
	input  logic [DATA_WIDTH-1:0] a_in,
	input  logic [DATA_WIDTH-1:0] b_in,
	input  logic [DATA_WIDTH-1:0] c_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);
	import smd_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] ma_q, mc_q, qn_q, rn_q, q_q, r_q;
	logic         qneg_q, rneg_q;
	logic [W-1:0] quot_q, rem_q;
	logic         out_valid_q;

	logic [W-1:0] c_fix, ma_in, mb_in, mc_in;
	logic [W-1:0] div_t, rn_dbl, r_sum;
	logic         div_ge, rn_ge, r_ge;

	// Operand magnitudes; the most negative value maps to 2^(W-1)
	assign c_fix = (c_in == '0) ? W'(1) : c_in;
	assign ma_in = a_in[W-1] ? (~a_in + 1'b1) : a_in;
	assign mb_in = b_in[W-1] ? (~b_in + 1'b1) : b_in;
	assign mc_in = c_fix[W-1] ? (~c_fix + 1'b1) : c_fix;

	// Restoring divide: next dividend bit shifts into the partial remainder
	assign div_t  = {rn_q[W-2:0], qn_q[W-1]};
	assign div_ge = (div_t >= mc_q);

	// Scaling step: doubled b/c remainder, and running remainder sum
	assign rn_dbl = {rn_q[W-2:0], 1'b0};
	assign rn_ge  = (rn_dbl >= mc_q);
	assign r_sum  = r_q + rn_q;
	assign r_ge   = (r_sum >= mc_q);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ma_q   <= ma_in;
			mc_q   <= mc_in;
			qn_q   <= mb_in;
			rn_q   <= '0;
			q_q    <= '0;
			r_q    <= '0;
			rneg_q <= a_in[W-1] ^ b_in[W-1];
			qneg_q <= a_in[W-1] ^ b_in[W-1] ^ c_fix[W-1];
		end else if (cmd.div_step) begin
			qn_q <= {qn_q[W-2:0], div_ge};
			rn_q <= div_ge ? (div_t - mc_q) : div_t;
		end else if (cmd.mul_step) begin
			ma_q <= {1'b0, ma_q[W-1:1]};
			if (ma_q[0]) begin
				q_q <= q_q + qn_q + W'(r_ge);
				r_q <= r_ge ? (r_sum - mc_q) : r_sum;
			end
			qn_q <= {qn_q[W-2:0], 1'b0} + W'(rn_ge);
			rn_q <= rn_ge ? (rn_dbl - mc_q) : rn_dbl;
		end
	end

	// Result register with signs applied
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			quot_q <= qneg_q ? (~q_q + 1'b1) : q_q;
			rem_q  <= rneg_q ? (~r_q + 1'b1) : r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.slot_free = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign quotient       = quot_q;
	assign remainder      = rem_q;

endmodule

### design/signed_multiply_divide.sv
// Top level of the signed scaled multiply-divide block.
// Computes (multiplicand * multiplier) / divisor and its remainder on signed
// DATA_WIDTH-bit operands without forming the double-width product. A zero
// divisor counts as one, the quotient keeps its low DATA_WIDTH bits, and the
// remainder carries the sign of the product. One request is worked at a time:
// after acceptance the datapath runs a restoring divide of the multiplier by
// the divisor, then a shift-and-add over the multiplicand bits, and then
// writes the result register; only after that write is a new request taken.
// The result register decouples the output, so the next request is accepted
// while a result still waits; a stalled output holds the block only at result
// write.
module signed_multiply_divide #(
	parameter int DATA_WIDTH = smd_pkg::DATA_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	smd_in_if.sink   operands,
	smd_out_if.source results
);
	import smd_pkg::*;

	cmd_t                  cmd;
	stat_t                 stat;
	logic [DATA_WIDTH-1:0] quot, rem;

	smd_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(operands.valid),
		.in_ready(operands.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	smd_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.a_in     (DATA_WIDTH'(operands.multiplicand)),
		.b_in     (DATA_WIDTH'(operands.multiplier)),
		.c_in     (DATA_WIDTH'(operands.divisor)),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.quotient (quot),
		.remainder(rem)
	);

	assign results.quotient  = $signed(quot);
	assign results.remainder = $signed(rem);

endmodule

### design/smd_checker.sv
// Port-level checker for the multiply-divide block, bound to the top level.
module smd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// Result request holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped before it was taken");

	// An accepted request occupies the block
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a request was accepted");

	// A new result appears only as the block goes free again
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result appeared outside the finish step");

	// No result right after acceptance when none was pending
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after acceptance");

endmodule

bind signed_multiply_divide smd_checker u_smd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (operands.valid),
	.in_ready (operands.ready),
	.out_valid(results.valid),
	.out_ready(results.ready)
);

### tb/sv/tb_signed_multiply_divide.sv
// Testbench for signed_multiply_divide: directed and random requests checked against a predictor.
module tb_signed_multiply_divide;

	localparam int W = smd_pkg::DATA_WIDTH_DEF;
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
	localparam int IDLE_PCT = 31;

	typedef struct packed {
		logic [W-1:0] multiplicand;
		logic [W-1:0] multiplier;
		logic [W-1:0] divisor;
	} operands_t;

	typedef struct packed {
		logic [W-1:0] quotient;
		logic [W-1:0] remainder;
	} quot_rem_t;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   sent_count;
	int   checked_count;
	int   error_count;
	quot_rem_t quotient_queue[$];

	smd_in_if  #(.W(W)) ops();
	smd_out_if #(.W(W)) res();

	signed_multiply_divide #(.DATA_WIDTH(W)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.operands(ops.sink),
		.results(res.source)
	);

	always #5 clk = ~clk;

	// Magnitude of a two's complement word; the most negative value maps to 2^(W-1)
	function automatic logic [W-1:0] magnitude_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// Expected quotient and remainder of (a*b)/c, signs applied to magnitudes
	function automatic quot_rem_t scale_divide(input operands_t op);
		logic [W-1:0]   den;
		logic [2*W-1:0] mag_a;
		logic [2*W-1:0] mag_b;
		logic [2*W-1:0] mag_c;
		logic [2*W-1:0] prod;
		logic [2*W-1:0] q;
		logic [2*W-1:0] r;
		logic [W-1:0]   q_low;
		logic [W-1:0]   r_low;
		bit             r_neg;
		bit             q_neg;
		quot_rem_t      out;
		den = (op.divisor == '0) ? W'(1) : op.divisor;
		r_neg = op.multiplicand[W-1] ^ op.multiplier[W-1];
		q_neg = r_neg ^ den[W-1];
		mag_a = {{W{1'b0}}, magnitude_of(op.multiplicand)};
		mag_b = {{W{1'b0}}, magnitude_of(op.multiplier)};
		mag_c = {{W{1'b0}}, magnitude_of(den)};
		prod = mag_a * mag_b;
		q = prod / mag_c;
		r = prod % mag_c;
		q_low = q[W-1:0];
		r_low = r[W-1:0];
		out.quotient = q_neg ? (~q_low + 1'b1) : q_low;
		out.remainder = r_neg ? (~r_low + 1'b1) : r_low;
		return out;
	endfunction

	// Send one request, with an optional idle gap; valid stays high for the next call
	task automatic issue_request(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] c);
		operands_t op;
		int        gap;
		op = '{a, b, c};
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			// mostly short gaps, now and then one spanning a whole computation
			gap = ($urandom_range(9) == 0) ? $urandom_range(1, 4*W + 10) : $urandom_range(1, 3);
			ops.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ops.valid <= 1'b1;
		ops.multiplicand <= a;
		ops.multiplier <= b;
		ops.divisor <= c;
		do @(posedge clk); while (!ops.ready);
		quotient_queue.push_back(scale_divide(op));
		sent_count++;
	endtask

	// Zero, one, minus one and both extremes
	function automatic logic [W-1:0] corner_value();
		case ($urandom_range(4))
			0: return '0;
			1: return W'(1);
			2: return MINUS_ONE;
			3: return MOST_POS;
			default: return MOST_NEG;
		endcase
	endfunction

	function automatic logic [W-1:0] small_value(input int span);
		return W'($urandom_range(0, 2*span) - span);
	endfunction

	// Operand mix: full range, small, tiny divisors (quotient wrap), corners, divisors within +/-2^16, powers of two
	function automatic operands_t random_operands();
		operands_t op;
		op = '{W'($urandom()), W'($urandom()), W'($urandom())};
		case ($urandom_range(5))
			0: ;
			1: op = '{small_value(255), small_value(255), small_value(255)};
			2: op.divisor = small_value(4);
			3: begin
				if ($urandom_range(1)) op.multiplicand = corner_value();
				if ($urandom_range(1)) op.multiplier = corner_value();
				if ($urandom_range(1)) op.divisor = corner_value();
			end
			4: op.divisor = small_value(1 << $urandom_range(1, 16));
			default: begin
				op.divisor = W'(1) << $urandom_range(W-1);
				if ($urandom_range(1)) op.divisor = ~op.divisor + 1'b1;
			end
		endcase
		return op;
	endfunction

	task automatic test_directed_extremes();
		issue_request('0, '0, '0);
		issue_request(W'(5), W'(7), '0);
		issue_request(W'(7), W'(5), W'(3));
		issue_request(-W'(7), W'(5), W'(3));
		issue_request(W'(7), -W'(5), W'(3));
		issue_request(W'(7), W'(5), -W'(3));
		issue_request(-W'(7), -W'(5), -W'(3));
		issue_request(-W'(7), -W'(5), W'(3));
		issue_request(MOST_POS, MOST_POS, W'(1));
		issue_request(MOST_NEG, MOST_NEG, W'(1));
		issue_request(MOST_NEG, MOST_NEG, MOST_NEG);
		issue_request(MOST_NEG, W'(1), MINUS_ONE);
		issue_request(MOST_POS, MOST_POS, MOST_POS);
		issue_request(MOST_POS, MOST_POS, MOST_NEG);
		issue_request(MOST_NEG, MOST_POS, MOST_POS);
		issue_request(MINUS_ONE, MINUS_ONE, MINUS_ONE);
		issue_request(W'(1), W'(1), MOST_NEG);
		issue_request(MINUS_ONE, W'(1), MOST_NEG);
		issue_request(MOST_POS, MOST_NEG, '0);
		issue_request('0, MOST_NEG, MOST_NEG);
		issue_request(W'(3), MOST_POS, W'(7));
		issue_request(MOST_POS, MINUS_ONE, W'(2));
		issue_request(W'(12345), -W'(6789), -W'(97));
		issue_request(MINUS_ONE, MOST_NEG, '0);
	endtask

	task automatic test_random_operands(input int count);
		operands_t op;
		repeat (count) begin
			op = random_operands();
			issue_request(op.multiplicand, op.multiplier, op.divisor);
		end
	endtask

	// Both sides always ready: requests back to back at the block's full rate
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_operands(count);
		no_idle = 1'b0;
	endtask

	// Result check against the oldest prediction; receiver stalls at random
	always @(posedge clk) begin : result_check
		quot_rem_t want;
		if (arst_n && res.valid && res.ready) begin
			if (quotient_queue.size() == 0) begin
				$error("unexpected result: quotient %0d remainder %0d",
					res.quotient, res.remainder);
				error_count++;
			end else begin
				want = quotient_queue.pop_front();
				checked_count++;
				if (res.quotient !== want.quotient) begin
					$error("quotient: expected %0d, actual %0d",
						$signed(want.quotient), res.quotient);
					error_count++;
				end
				if (res.remainder !== want.remainder) begin
					$error("remainder: expected %0d, actual %0d",
						$signed(want.remainder), res.remainder);
					error_count++;
				end
			end
		end
		res.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		no_idle = 1'b0;
		ops.valid = 1'b0;
		ops.multiplicand = '0;
		ops.multiplier = '0;
		ops.divisor = '0;
		res.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_random_operands(180);
		test_back_to_back(80);
		test_random_operands(190);
		ops.valid <= 1'b0;

		// drain outstanding results, then let the datapath settle
		while (quotient_queue.size() != 0) @(posedge clk);
		repeat (2*W + 4) @(posedge clk);

		$display("Run covered %0d requests: operand extremes, zero divisor, quotient wrap,",
			sent_count);
		$display("random operand mixes with idle and stall, back to back; %0d results checked",
			checked_count);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
